FILE: rtl/wbps_pkg.sv
// wbps_pkg: word types, codes and constants of the wildcard byte pattern scanner
// used by wbps_cell and wildcard_byte_pattern_scan; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BEGIN = 2'd1,
		OP_DATA  = 2'd2,
		OP_END   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_PATTERN_LENGTH  = 2'd0,
		REG_MAX_OCCURRENCES = 2'd1,
		REG_PATCH_OFFSET    = 2'd2,
		REG_REGION_BASE     = 2'd3
	} reg_index_t;

	localparam logic       KIND_MATCH   = 1'b0;
	localparam logic       KIND_SUMMARY = 1'b1;
	localparam logic [7:0] WILDCARD     = 8'hff;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] pattern_index;
		logic [7:0] byte_value;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] match_start;
		logic [63:0] patch_address;
		logic [31:0] occurrence_number;
		logic        not_found;
	} out_word_t;

	typedef struct packed {
		logic       load;
		logic       scan;
		logic       clear;
		logic       usable;
		logic [7:0] pattern_index;
		logic [7:0] byte_value;
		logic [7:0] len;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/wbps_cell.sv
// wbps_cell: one pattern cell, holding a pattern byte and its partial-match bit
// depends on wbps_pkg
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell #(
	parameter int INDEX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wbps_pkg::cell_ctrl_t ctrl,
	input  wire                 prev,
	output logic                hit,
	output logic                tail
);

	logic [7:0] pattern_q;
	logic       hit_q;
	logic       active;
	logic       eq;

	assign active = ctrl.usable && (32'(INDEX) < 32'(ctrl.len));
	assign eq     = (pattern_q == wbps_pkg::WILDCARD) || (pattern_q == ctrl.byte_value);

	always_ff @(posedge clk) begin
		if (ctrl.load && (32'(ctrl.pattern_index) == 32'(INDEX))) begin
			pattern_q <= ctrl.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (ctrl.scan && active) begin
			hit_q <= eq && prev;
		end
	end

	assign hit  = hit_q;
	assign tail = hit_q && (32'(INDEX) + 32'd1 == 32'(ctrl.len));

endmodule

`default_nettype wire

FILE: rtl/wildcard_byte_pattern_scan.sv
// wildcard_byte_pattern_scan: top level, chain of pattern cells, position and count
// depends on wbps_pkg and wbps_cell
//
// channel  direction  handshake            word
// in       in         in_valid / in_stall  wbps_pkg::in_word_t
// out      out        out_valid / out_stall wbps_pkg::out_word_t
// cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle while not stalled; results pass stage one and the output register
// every cell compares its byte in the same cycle and the match bits move one cell per byte
// reset clears match bits, position, count, config; length 1; pattern bytes need loading
// out_stall holds the output register and the report stage, and in_stall follows them
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scan #(
	parameter int PATTERN_CELLS = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wbps_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  wire                 out_stall,
	output wbps_pkg::out_word_t out_word,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [1:0]           cfg_index,
	input  wire [63:0]          cfg_data
);

	logic [7:0]  len_q;
	logic [31:0] max_q;
	logic [31:0] off_q;
	logic [63:0] base_q;
	logic [31:0] pos_q;
	logic [31:0] count_q;

	logic                valid_s1;
	wbps_pkg::opcode_t   op_s1;
	logic [31:0]         start_s1;
	logic                scan_s1;

	logic                out_valid_q;
	wbps_pkg::out_word_t out_word_q;

	logic                 out_free;
	logic                 advance;
	logic                 accept;
	logic                 pos_sat;
	logic                 usable;
	logic                 limited;
	logic                 hit;
	logic [31:0]          count_inc;
	wbps_pkg::cell_ctrl_t ctrl;
	logic [PATTERN_CELLS-1:0] bits;
	logic [PATTERN_CELLS-1:0] tails;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = !valid_s1 || out_free;
	assign in_stall  = !advance;
	assign accept    = in_valid && advance;
	assign pos_sat   = (pos_q == 32'hffff_ffff);
	assign usable    = (len_q != 8'd0) && (32'(len_q) <= 32'(PATTERN_CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 8'd1;
			max_q  <= 32'd0;
			off_q  <= 32'd0;
			base_q <= 64'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wbps_pkg::REG_PATTERN_LENGTH:  len_q  <= cfg_data[7:0];
				wbps_pkg::REG_MAX_OCCURRENCES: max_q  <= cfg_data[31:0];
				wbps_pkg::REG_PATCH_OFFSET:    off_q  <= cfg_data[31:0];
				wbps_pkg::REG_REGION_BASE:     base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell controls for the word taken this cycle
	always_comb begin
		ctrl.load          = accept && (in_word.opcode == wbps_pkg::OP_LOAD);
		ctrl.scan          = accept && (in_word.opcode == wbps_pkg::OP_DATA) && !pos_sat;
		ctrl.clear         = accept && ((in_word.opcode == wbps_pkg::OP_BEGIN) ||
			(in_word.opcode == wbps_pkg::OP_END));
		ctrl.usable        = usable;
		ctrl.pattern_index = in_word.pattern_index;
		ctrl.byte_value    = in_word.byte_value;
		ctrl.len           = len_q;
	end

	for (genvar k = 0; k < PATTERN_CELLS; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = bits[k-1];
		end
		wbps_cell #(.INDEX(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.prev   (prev),
			.hit    (bits[k]),
			.tail   (tails[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 32'd0;
		end else if (ctrl.clear) begin
			pos_q <= 32'd0;
		end else if (ctrl.scan) begin
			pos_q <= pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1    <= in_word.opcode;
			start_s1 <= pos_q - 32'(len_q) + 32'd1;
			scan_s1  <= !pos_sat;
		end
	end

	// match bits now hold the state after the word in stage one
	assign hit       = scan_s1 && usable && (|tails);
	assign limited   = (max_q != 32'd0) && (count_q >= max_q);
	assign count_inc = (count_q == 32'hffff_ffff) ? count_q : count_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
			if (valid_s1) begin
				case (op_s1)
					wbps_pkg::OP_BEGIN: count_q <= 32'd0;
					wbps_pkg::OP_END: begin
						count_q     <= 32'd0;
						out_valid_q <= 1'b1;
					end
					wbps_pkg::OP_DATA: begin
						if (hit && !limited) begin
							count_q     <= count_inc;
							out_valid_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (op_s1 == wbps_pkg::OP_END) begin
				out_word_q.result_kind       <= wbps_pkg::KIND_SUMMARY;
				out_word_q.match_start       <= 32'd0;
				out_word_q.patch_address     <= 64'd0;
				out_word_q.occurrence_number <= count_q;
				out_word_q.not_found         <= (count_q == 32'd0);
			end else begin
				out_word_q.result_kind       <= wbps_pkg::KIND_MATCH;
				out_word_q.match_start       <= start_s1;
				out_word_q.patch_address     <= base_q + {32'd0, start_s1} +
					{{32{off_q[31]}}, off_q};
				out_word_q.occurrence_number <= count_inc;
				out_word_q.not_found         <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire
